FILE: rtl/assert_macros.svh
// Assertion macros for the checker; clk and rst_n come from the user's scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LPHT_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpht assertion failed");

// Next-cycle implication.
`define LPHT_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpht assertion failed");

`endif

FILE: rtl/lpht_pkg.sv
// Types and codes shared by the hash table unit and its checker.
`timescale 1ns / 1ps

package lpht_pkg;

    localparam int SLOT_OUT_W = 4;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_SEARCH = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    typedef enum logic [2:0] {
        RES_ADDED   = 3'd0,
        RES_DUP     = 3'd1,
        RES_FULL    = 3'd2,
        RES_FOUND   = 3'd3,
        RES_MISS    = 3'd4,
        RES_DELETED = 3'd5
    } result_t;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_USED  = 2'd1,
        ST_TOMB  = 2'd2
    } slot_state_t;

endpackage

FILE: rtl/linear_probe_hash_table_unit.sv
// Open-addressing hash table with linear probing, tombstones and a sequential probe engine.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------------
//   in      | in_valid / in_stall  | action, key, soil_code, crop_code, yield_tenths
//   out     | out_valid / out_stall| status, slot, found_soil, found_crop, found_yield
//
// One transfer in, then slots are probed in turn from the home slot (1 to TABLE_SLOTS
// of them) through the registered slot read port of the status and record memories.
// When TABLE_SLOTS is not a power of two, the home-slot remainder is first reduced on
// one shared compare-subtract unit. After reset a clearing pass empties the status
// memory; in_stall stays high meanwhile. in_stall is high while an item is in work; a
// stalled result holds and the next item is still taken, but it cannot finish until the held result is taken.
`timescale 1ns / 1ps

module linear_probe_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int TABLE_SLOTS = 16,
    parameter int KEY_BYTES   = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [63:0] key,
    input  logic [7:0]  soil_code,
    input  logic [7:0]  crop_code,
    input  logic [15:0] yield_tenths,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [3:0]  slot,
    output logic [7:0]  found_soil,
    output logic [7:0]  found_crop,
    output logic [15:0] found_yield
);

    localparam int IDX_W  = $clog2(TABLE_SLOTS);
    localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
    localparam int KEY_W  = 8 * KEY_BYTES;
    localparam int REC_W  = KEY_W + 32;
    localparam int SUM_W  = $clog2(KEY_BYTES * 255 + 1);
    localparam int DW     = SUM_W + IDX_W + 1;
    localparam bit POW2   = ((1 << IDX_W) == TABLE_SLOTS);
    localparam int K0     = (SUM_W > IDX_W) ? (SUM_W - IDX_W) : 0;
    localparam int STEP_W = $clog2(K0 + 2);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_PROBE
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              tomb_valid_reg, tomb_valid_next;
    logic [IDX_W-1:0]  tomb_idx_reg, tomb_idx_next;
    logic [1:0]        action_reg, action_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [7:0]        soil_reg, soil_next;
    logic [7:0]        crop_reg, crop_next;
    logic [15:0]       yield_reg, yield_next;
    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [DW-1:0]     div_reg, div_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    result_t           status_reg, status_next;
    logic [3:0]        slot_reg, slot_next;
    logic [7:0]        fsoil_reg, fsoil_next;
    logic [7:0]        fcrop_reg, fcrop_next;
    logic [15:0]       fyield_reg, fyield_next;

    slot_state_t       stat_mem [TABLE_SLOTS];
    logic [REC_W-1:0]  rec_mem  [TABLE_SLOTS];
    slot_state_t       stat_rd_reg;
    logic [REC_W-1:0]  rec_rd_reg;

    logic [IDX_W-1:0]  rd_addr;
    logic              stat_we;
    logic [IDX_W-1:0]  stat_wa;
    slot_state_t       stat_wd;
    logic              rec_we;
    logic [IDX_W-1:0]  rec_wa;
    logic [REC_W-1:0]  rec_wd;

    logic [SUM_W-1:0]  sum_in;
    logic [DW-1:0]     sum_ext;

    always_comb
    begin
        sum_in = '0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            sum_in = sum_in + SUM_W'(key[8*i +: 8]);
        end
    end

    assign sum_ext = DW'(sum_in);

    always_comb
    begin
        logic              out_free;
        logic              key_hit;
        logic              wrap;
        logic [CNT_W-1:0]  cnt_inc;
        logic              tv;
        logic [IDX_W-1:0]  ti;
        logic              finish;
        result_t           res;
        logic [IDX_W-1:0]  res_slot;
        logic              res_found;
        logic              do_stat_we;
        slot_state_t       do_stat_wd;
        logic              do_rec_we;
        logic [IDX_W-1:0]  wr_idx;
        logic [DW-1:0]     rem_ext;
        logic [DW-1:0]     diff;
        logic [IDX_W+3:0]  slot_ext;

        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        tomb_valid_next = tomb_valid_reg;
        tomb_idx_next   = tomb_idx_reg;
        action_next     = action_reg;
        key_next        = key_reg;
        soil_next       = soil_reg;
        crop_next       = crop_reg;
        yield_next      = yield_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        fsoil_next      = fsoil_reg;
        fcrop_next      = fcrop_reg;
        fyield_next     = fyield_reg;

        stat_we = 1'b0;
        stat_wa = idx_reg;
        stat_wd = ST_EMPTY;
        rec_we  = 1'b0;
        rec_wa  = idx_reg;
        rec_wd  = {key_reg, soil_reg, crop_reg, yield_reg};

        out_free = !out_valid_reg || !out_stall;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        key_hit    = (rec_rd_reg[REC_W-1 -: KEY_W] == key_reg);
        cnt_inc    = cnt_reg + CNT_W'(1);
        wrap       = (cnt_inc == CNT_W'(TABLE_SLOTS));
        tv         = tomb_valid_reg || (stat_rd_reg == ST_TOMB);
        ti         = tomb_valid_reg ? tomb_idx_reg : idx_reg;
        finish     = 1'b0;
        res        = RES_MISS;
        res_slot   = '0;
        res_found  = 1'b0;
        do_stat_we = 1'b0;
        do_stat_wd = ST_USED;
        do_rec_we  = 1'b0;
        wr_idx     = idx_reg;
        rem_ext    = DW'(rem_reg);
        diff       = (rem_ext >= div_reg) ? (rem_ext - div_reg) : rem_ext;
        slot_ext   = '0;

        case (state_reg)
            S_CLEAR:
            begin
                stat_we = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    action_next     = action;
                    key_next        = key[KEY_W-1:0];
                    soil_next       = soil_code;
                    crop_next       = crop_code;
                    yield_next      = yield_tenths;
                    cnt_next        = '0;
                    tomb_valid_next = 1'b0;
                    if (POW2)
                    begin
                        idx_next   = sum_ext[IDX_W-1:0];
                        state_next = S_PROBE;
                    end
                    else
                    begin
                        rem_next   = sum_in;
                        div_next   = DW'(TABLE_SLOTS) << K0;
                        step_next  = STEP_W'(K0);
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                rem_next  = diff[SUM_W-1:0];
                div_next  = div_reg >> 1;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    idx_next   = diff[IDX_W-1:0];
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                case (action_reg)
                    ACT_INSERT:
                    begin
                        if (stat_rd_reg == ST_EMPTY)
                        begin
                            finish     = 1'b1;
                            wr_idx     = ti;
                            do_stat_we = 1'b1;
                            do_rec_we  = 1'b1;
                            res        = RES_ADDED;
                            res_slot   = ti;
                        end
                        else if (stat_rd_reg == ST_USED && key_hit)
                        begin
                            finish   = 1'b1;
                            res      = RES_DUP;
                            res_slot = idx_reg;
                        end
                        else if (wrap)
                        begin
                            finish = 1'b1;
                            if (tv)
                            begin
                                wr_idx     = ti;
                                do_stat_we = 1'b1;
                                do_rec_we  = 1'b1;
                                res        = RES_ADDED;
                                res_slot   = ti;
                            end
                            else
                            begin
                                res = RES_FULL;
                            end
                        end
                    end
                    ACT_SEARCH, ACT_DELETE:
                    begin
                        if (stat_rd_reg == ST_EMPTY)
                        begin
                            finish = 1'b1;
                        end
                        else if (stat_rd_reg == ST_USED && key_hit)
                        begin
                            finish   = 1'b1;
                            res_slot = idx_reg;
                            if (action_reg == ACT_SEARCH)
                            begin
                                res       = RES_FOUND;
                                res_found = 1'b1;
                            end
                            else
                            begin
                                res        = RES_DELETED;
                                do_stat_we = 1'b1;
                                do_stat_wd = ST_TOMB;
                            end
                        end
                        else if (wrap)
                        begin
                            finish = 1'b1;
                        end
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase

                if (finish)
                begin
                    if (out_free)
                    begin
                        stat_we        = do_stat_we;
                        stat_wa        = wr_idx;
                        stat_wd        = do_stat_wd;
                        rec_we         = do_rec_we;
                        rec_wa         = wr_idx;
                        slot_ext       = {4'b0, res_slot};
                        out_valid_next = 1'b1;
                        status_next    = res;
                        slot_next      = slot_ext[3:0];
                        fsoil_next     = res_found ? rec_rd_reg[31:24] : 8'd0;
                        fcrop_next     = res_found ? rec_rd_reg[23:16] : 8'd0;
                        fyield_next    = res_found ? rec_rd_reg[15:0] : 16'd0;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    idx_next        = (idx_reg == LAST_IDX) ? '0 : idx_reg + IDX_W'(1);
                    cnt_next        = cnt_inc;
                    tomb_valid_next = tv;
                    tomb_idx_next   = ti;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        rd_addr = idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            tomb_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            step_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            tomb_valid_reg <= tomb_valid_next;
            out_valid_reg  <= out_valid_next;
            step_reg       <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tomb_idx_reg <= tomb_idx_next;
        action_reg   <= action_next;
        key_reg      <= key_next;
        soil_reg     <= soil_next;
        crop_reg     <= crop_next;
        yield_reg    <= yield_next;
        rem_reg      <= rem_next;
        div_reg      <= div_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        fsoil_reg    <= fsoil_next;
        fcrop_reg    <= fcrop_next;
        fyield_reg   <= fyield_next;
    end

    always_ff @(posedge clk)
    begin
        if (stat_we)
        begin
            stat_mem[stat_wa] <= stat_wd;
        end
        stat_rd_reg <= stat_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[rec_wa] <= rec_wd;
        end
        rec_rd_reg <= rec_mem[rd_addr];
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign slot        = slot_reg;
    assign found_soil  = fsoil_reg;
    assign found_crop  = fcrop_reg;
    assign found_yield = fyield_reg;

endmodule

FILE: rtl/lpht_checker.sv
// Port-level checker for the hash table unit, bound into the unit module.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpht_checker
    import lpht_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [3:0]  slot,
    input logic [7:0]  found_soil,
    input logic [7:0]  found_crop,
    input logic [15:0] found_yield
);

    logic found_zero;

    assign found_zero = (found_soil == 8'd0) && (found_crop == 8'd0) && (found_yield == 16'd0);

    `LPHT_ASSERT_NXT(a_busy_after_xfer, in_valid && !in_stall, in_stall)
    `LPHT_ASSERT_IMP(a_status_code, out_valid, status <= RES_DELETED)
    `LPHT_ASSERT_IMP(a_fields_zero, out_valid && status != RES_FOUND, found_zero)
    `LPHT_ASSERT_IMP(a_no_slot, out_valid && (status == RES_FULL || status == RES_MISS), slot == 4'd0)
    `LPHT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(slot))

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (.*);
